// ===== design/wildcard_glob_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_defines
// assertion macros shared by the glob matcher modules
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WGM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wgm assertion failed");

// next-cycle implication
`define WGM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wgm assertion failed");

`else

`define WGM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WGM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg
// types and constants of the wildcard glob matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

    localparam int SYM_W   = 21;
    localparam int INDEX_W = 5;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 6;

    localparam logic [SYM_W-1:0] STAR_CP     = SYM_W'('h2A);
    localparam logic [SYM_W-1:0] QUESTION_CP = SYM_W'('h3F);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_TARGET = 2'd2
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        logic advance;
        logic active;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/wgm_if.sv =====
// ----------------------------------------------------------------------------
// wgm_if
// input and result channels of the wildcard glob matcher
// ----------------------------------------------------------------------------
`default_nettype none

interface wgm_in_if;
    import wgm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] index;
    logic [SYM_W-1:0]   symbol;

    modport source (output valid, output operation, output index, output symbol,
                    input ready);
    modport sink   (input valid, input operation, input index, input symbol,
                    output ready);
endinterface

interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

`default_nettype wire

// ===== design/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell
// one pattern position: stored symbol, reachable bit, star closure link
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_first,
    input  wgm_pkg::t_cell_ctl       i_ctl,
    input  logic [wgm_pkg::SYM_W-1:0] i_symbol,
    input  logic                     i_pass,
    input  logic                     i_carry,
    output logic                     o_pass,
    output logic                     o_carry,
    output logic                     o_closed,
    output logic                     o_reach
);
    import wgm_pkg::*;

    logic [SYM_W-1:0] r_sym;
    logic             r_reach;
    logic             n_reach;
    logic             is_star;
    logic             hit;
    logic             live;

    assign is_star = (r_sym == STAR_CP);
    assign hit     = is_star || (r_sym == QUESTION_CP) || (r_sym == i_symbol);
    assign live    = r_reach && i_ctl.active && i_ctl.advance;

    // next bit before closure, then closure from the left neighbor
    assign n_reach  = (live && is_star) || i_pass;
    assign o_closed = n_reach || i_carry;
    assign o_carry  = o_closed && i_ctl.active && is_star;
    assign o_pass   = live && hit;
    assign o_reach  = r_reach;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sym <= i_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach <= i_first;
        end else if (i_ctl.start || i_ctl.advance) begin
            r_reach <= o_closed;
        end
    end

endmodule

`default_nettype wire

// ===== design/wgm_out_stage.sv =====
// ----------------------------------------------------------------------------
// wgm_out_stage
// result register with a skid entry behind it
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wgm_out_stage (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_matched,
    output logic      o_room,
    wgm_out_if.source o_out
);
    logic r_out_valid;
    logic r_out_matched;
    logic r_skid_valid;
    logic r_skid_matched;
    logic out_xfer;

    assign out_xfer      = r_out_valid && o_out.ready;
    assign o_room        = !r_skid_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.matched = r_out_matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid && out_xfer) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && out_xfer) begin
            r_out_matched <= r_skid_matched;
        end else if (i_push) begin
            if (!r_out_valid || out_xfer) begin
                r_out_matched <= i_matched;
            end else begin
                r_skid_matched <= i_matched;
            end
        end
    end

    `WGM_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `WGM_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n, i_push && r_out_valid && !o_out.ready, r_skid_valid)
    `WGM_ASSERT_NXT(a_drain_empties, i_clk, i_rst_n, out_xfer && !r_skid_valid && !i_push, !r_out_valid)

endmodule

`default_nettype wire

// ===== design/wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// glob matcher with '*' and '?' over codepoints, one cell per pattern position
//
//   channel   dir  handshake          payload
//   i_cfg     in   valid / ready      pattern_length (6 bits)
//   i_in      in   valid / ready      operation, index, symbol
//   o_out     out  valid / ready      matched
//
// one item per cycle while i_in is not stalled; a begin or target item's result is registered
// the star closure ripples through the cell row in the cycle of the transfer
// a result register plus a skid entry; i_in stalls once both hold a result
// synchronous active-low reset: only position zero reachable, length zero
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [wgm_pkg::CFG_W-1:0] i_cfg_data,
    wgm_in_if.sink                    i_in,
    wgm_out_if.source                 o_out
);
    import wgm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam int LOAD_SPAN = 2 ** INDEX_W;

    logic [CFG_W-1:0]     r_pat_len;
    logic [CW-1:0]        len_wide;
    logic [LW-1:0]        len_used;
    logic                 in_xfer;
    logic                 room;
    logic                 load;
    logic                 start;
    logic                 adv;
    logic                 r_end;
    logic [PATTERN_MAX:0] pass_v;
    logic [PATTERN_MAX:0] carry_v;
    logic [PATTERN_MAX:0] closed_v;
    logic [PATTERN_MAX:0] reach_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
        end else if (i_cfg_valid) begin
            r_pat_len <= i_cfg_data;
        end
    end

    assign len_wide = (CW'(r_pat_len) > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX)
                                                          : CW'(r_pat_len);
    assign len_used = LW'(len_wide);

    assign i_in.ready = room;
    assign in_xfer    = i_in.valid && room;

    always_comb begin
        load  = 1'b0;
        start = 1'b0;
        adv   = 1'b0;
        if (in_xfer) begin
            unique case (t_op'(i_in.operation))
                OP_LOAD:   load  = 1'b1;
                OP_BEGIN:  start = 1'b1;
                OP_TARGET: adv   = 1'b1;
                default:   ;
            endcase
        end
    end

    assign pass_v[0]  = start;
    assign carry_v[0] = 1'b0;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        localparam bit CAN_LOAD = (i < LOAD_SPAN);
        t_cell_ctl ctl;

        assign ctl.load    = load && CAN_LOAD && (i_in.index == INDEX_W'(i));
        assign ctl.start   = start;
        assign ctl.advance = adv;
        assign ctl.active  = (CW'(i) < len_wide);

        wgm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_first  ((i == 0) ? 1'b1 : 1'b0),
            .i_ctl    (ctl),
            .i_symbol (i_in.symbol),
            .i_pass   (pass_v[i]),
            .i_carry  (carry_v[i]),
            .o_pass   (pass_v[i+1]),
            .o_carry  (carry_v[i+1]),
            .o_closed (closed_v[i]),
            .o_reach  (reach_v[i])
        );
    end

    // position past the last symbol has no pattern entry
    assign closed_v[PATTERN_MAX] = pass_v[PATTERN_MAX] || carry_v[PATTERN_MAX];
    assign reach_v[PATTERN_MAX]  = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end <= 1'b0;
        end else if (start || adv) begin
            r_end <= closed_v[PATTERN_MAX];
        end
    end

    wgm_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (start || adv),
        .i_matched (closed_v[len_used]),
        .o_room    (room),
        .o_out     (o_out)
    );

    `WGM_ASSERT_NXT(a_begin_seeds, i_clk, i_rst_n, start, reach_v[0])
    `WGM_ASSERT_NXT(a_hold_when_quiet, i_clk, i_rst_n, !start && !adv, $stable(reach_v))
    `WGM_ASSERT_NXT(a_dead_stays_dead, i_clk, i_rst_n, adv && (reach_v == '0), reach_v == '0)

endmodule

`default_nettype wire
